[src/ase_pkg.sv]
// ----------------------------------------------------------------------------
// ARM subset execute unit package
// Shared constants and the register update request passed from the
// execute datapath to the architectural state.
// ----------------------------------------------------------------------------
package ase_pkg;

  localparam logic        FUNC_EXEC    = 1'b0;
  localparam logic        FUNC_WRITE   = 1'b1;

  localparam logic [23:0] BX_PATTERN   = 24'b0001_0010_1111_1111_1111_0001;
  localparam logic [3:0]  MUL_NIBBLE   = 4'b1001;
  localparam logic [2:0]  BRANCH_CODE  = 3'b101;

  localparam logic [3:0]  OPC_MOV      = 4'b1101;
  localparam logic [3:0]  OPC_ADD      = 4'b0100;
  localparam logic [3:0]  OPC_SUB      = 4'b0010;
  localparam logic [3:0]  OPC_CMP      = 4'b1010;

  localparam logic [3:0]  PC_IDX       = 4'd15;
  localparam logic [3:0]  LR_IDX       = 4'd14;
  localparam logic [3:0]  R0_IDX       = 4'd0;

  // Flag vector layout: N, Z, C, V from bit 3 down to bit 0.
  localparam int          FLAG_N       = 3;
  localparam int          FLAG_Z       = 2;
  localparam int          FLAG_C       = 1;
  localparam int          FLAG_V       = 0;

  typedef struct packed {
    logic        gpr_we;
    logic [3:0]  gpr_idx;
    logic [31:0] gpr_data;
    logic        pc_we;
    logic [31:0] pc_data;
    logic        flags_we;
    logic [3:0]  flags;
  } upd_req_t;

endpackage

[src/arm_subset_execute_unit.sv]
// A request is captured in the input register and its result in the output register.
// Throughput: one request per cycle while out_ready holds; the input register, execute
// logic and output register form a two-stage pipe whose register file updates in the
// execute cycle. Reset: synchronous active-low rst_n clears all sixteen registers, the
// flags and both valid stages.
// ----------------------------------------------------------------------------
// ARM subset execute unit
// Executes one instruction word or register write per request against a
// flop-based register file and NZCV flags, returning PC, r0 and flags.
// ----------------------------------------------------------------------------
module arm_subset_execute_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [31:0] in_instr_word,
  input  logic [3:0]  in_reg_index,
  input  logic [31:0] in_write_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_next_pc,
  output logic        out_halted,
  output logic [31:0] out_return_value,
  output logic        out_flag_n,
  output logic        out_flag_z,
  output logic        out_flag_c,
  output logic        out_flag_v,
  output logic        out_illegal
);

  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic        s1_func_r;
  logic [31:0] s1_instr_r;
  logic [3:0]  s1_idx_r;
  logic [31:0] s1_val_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [31:0] out_pc_r;
  logic [31:0] out_r0_r;
  logic [3:0]  out_flags_r;
  logic        out_illegal_r;
  logic        advance;
  logic        in_fire;

  logic [3:0]        rn_idx;
  logic [3:0]        rm_idx;
  logic [3:0]        rs_idx;
  logic [31:0]       rn_data;
  logic [31:0]       rm_data;
  logic [31:0]       rs_data;
  logic [31:0]       pc_data;
  logic [31:0]       r0_data;
  logic [3:0]        flags;
  ase_pkg::upd_req_t upd;
  logic [31:0]       next_pc;
  logic [31:0]       return_value;
  logic [3:0]        flags_after;
  logic              illegal;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func_r  <= in_func;
      s1_instr_r <= in_instr_word;
      s1_idx_r   <= in_reg_index;
      s1_val_r   <= in_write_value;
    end
    if (advance) begin
      out_pc_r      <= next_pc;
      out_r0_r      <= return_value;
      out_flags_r   <= flags_after;
      out_illegal_r <= illegal;
    end
  end

  ase_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd_en  (advance),
    .upd     (upd),
    .rn_idx  (rn_idx),
    .rm_idx  (rm_idx),
    .rs_idx  (rs_idx),
    .rn_data (rn_data),
    .rm_data (rm_data),
    .rs_data (rs_data),
    .pc_data (pc_data),
    .r0_data (r0_data),
    .flags   (flags)
  );

  ase_exec u_exec (
    .func         (s1_func_r),
    .instr_word   (s1_instr_r),
    .reg_index    (s1_idx_r),
    .write_value  (s1_val_r),
    .rn_data      (rn_data),
    .rm_data      (rm_data),
    .rs_data      (rs_data),
    .pc_data      (pc_data),
    .r0_data      (r0_data),
    .flags        (flags),
    .rn_idx       (rn_idx),
    .rm_idx       (rm_idx),
    .rs_idx       (rs_idx),
    .upd          (upd),
    .next_pc      (next_pc),
    .return_value (return_value),
    .flags_after  (flags_after),
    .illegal      (illegal)
  );

  assign out_valid        = out_valid_r;
  assign out_next_pc      = out_pc_r;
  assign out_halted       = (out_pc_r == 32'd0);
  assign out_return_value = out_r0_r;
  assign out_flag_n       = out_flags_r[ase_pkg::FLAG_N];
  assign out_flag_z       = out_flags_r[ase_pkg::FLAG_Z];
  assign out_flag_c       = out_flags_r[ase_pkg::FLAG_C];
  assign out_flag_v       = out_flags_r[ase_pkg::FLAG_V];
  assign out_illegal      = out_illegal_r;

endmodule

[src/ase_regfile.sv]
// ----------------------------------------------------------------------------
// ARM subset register file
// Sixteen 32-bit registers and the NZCV flags, with three read ports for
// the instruction operands and one update request applied per cycle while upd_en is set.
// ----------------------------------------------------------------------------
module ase_regfile (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              upd_en,
  input  ase_pkg::upd_req_t upd,
  input  logic [3:0]        rn_idx,
  input  logic [3:0]        rm_idx,
  input  logic [3:0]        rs_idx,
  output logic [31:0]       rn_data,
  output logic [31:0]       rm_data,
  output logic [31:0]       rs_data,
  output logic [31:0]       pc_data,
  output logic [31:0]       r0_data,
  output logic [3:0]        flags
);

  logic [31:0] regs_r [16];
  logic [3:0]  flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        regs_r[i] <= '0;
      end
      flags_r <= '0;
    end else if (upd_en) begin
      if (upd.gpr_we) begin
        regs_r[upd.gpr_idx] <= upd.gpr_data;
      end
      if (upd.pc_we) begin
        regs_r[ase_pkg::PC_IDX] <= upd.pc_data;
      end
      if (upd.flags_we) begin
        flags_r <= upd.flags;
      end
    end
  end

  assign rn_data = regs_r[rn_idx];
  assign rm_data = regs_r[rm_idx];
  assign rs_data = regs_r[rs_idx];
  assign pc_data = regs_r[ase_pkg::PC_IDX];
  assign r0_data = regs_r[ase_pkg::R0_IDX];
  assign flags   = flags_r;

endmodule

[src/ase_exec.sv]
// ----------------------------------------------------------------------------
// ARM subset execute datapath
// Decodes one request, computes its register, PC and flag updates, and
// forms the architectural view that follows it.
// ----------------------------------------------------------------------------
module ase_exec (
  input  logic              func,
  input  logic [31:0]       instr_word,
  input  logic [3:0]        reg_index,
  input  logic [31:0]       write_value,
  input  logic [31:0]       rn_data,
  input  logic [31:0]       rm_data,
  input  logic [31:0]       rs_data,
  input  logic [31:0]       pc_data,
  input  logic [31:0]       r0_data,
  input  logic [3:0]        flags,
  output logic [3:0]        rn_idx,
  output logic [3:0]        rm_idx,
  output logic [3:0]        rs_idx,
  output ase_pkg::upd_req_t upd,
  output logic [31:0]       next_pc,
  output logic [31:0]       return_value,
  output logic [3:0]        flags_after,
  output logic              illegal
);

  logic        is_bx;
  logic        is_mul;
  logic        is_dp;
  logic        is_br;
  logic [3:0]  opcode;
  logic [3:0]  rd_dp;
  logic [3:0]  rd_mul;
  logic [31:0] op2;
  logic [31:0] sum;
  logic [32:0] diff;
  logic [31:0] prod;
  logic [31:0] pc_plus4;
  logic [31:0] br_off;
  logic [31:0] br_target;
  logic [3:0]  cmp_flags;

  assign rm_idx = instr_word[3:0];
  assign rs_idx = instr_word[11:8];
  assign rn_idx = instr_word[19:16];
  assign rd_dp  = instr_word[15:12];
  assign rd_mul = instr_word[19:16];
  assign opcode = instr_word[24:21];

  assign is_bx  = (instr_word[27:4] == ase_pkg::BX_PATTERN);
  assign is_mul = (instr_word[27:22] == 6'd0) && (instr_word[7:4] == ase_pkg::MUL_NIBBLE);
  assign is_dp  = (instr_word[27:26] == 2'd0);
  assign is_br  = (instr_word[27:25] == ase_pkg::BRANCH_CODE);

  assign op2       = instr_word[25] ? {24'd0, instr_word[7:0]} : rm_data;
  assign sum       = rn_data + op2;
  assign diff      = {1'b0, rn_data} - {1'b0, op2};
  assign prod      = rm_data * rs_data;
  assign pc_plus4  = pc_data + 32'd4;
  assign br_off    = {{6{instr_word[23]}}, instr_word[23:0], 2'b00};
  assign br_target = pc_data + 32'd8 + br_off;

  always_comb begin
    cmp_flags                  = '0;
    cmp_flags[ase_pkg::FLAG_N] = diff[31];
    cmp_flags[ase_pkg::FLAG_Z] = (diff[31:0] == 32'd0);
    cmp_flags[ase_pkg::FLAG_C] = ~diff[32];
    cmp_flags[ase_pkg::FLAG_V] = (rn_data[31] ^ op2[31]) & (rn_data[31] ^ diff[31]);
  end

  always_comb begin
    upd      = '0;
    illegal  = 1'b0;
    if (func == ase_pkg::FUNC_WRITE) begin
      upd.gpr_we   = 1'b1;
      upd.gpr_idx  = reg_index;
      upd.gpr_data = write_value;
    end else if (is_bx) begin
      upd.pc_we   = 1'b1;
      upd.pc_data = rm_data;
    end else if (is_mul) begin
      upd.gpr_we   = 1'b1;
      upd.gpr_idx  = rd_mul;
      upd.gpr_data = prod;
      upd.pc_we    = (rd_mul != ase_pkg::PC_IDX);
      upd.pc_data  = pc_plus4;
    end else if (is_dp) begin
      upd.pc_data = pc_plus4;
      unique case (opcode)
        ase_pkg::OPC_MOV, ase_pkg::OPC_ADD, ase_pkg::OPC_SUB: begin
          upd.gpr_we  = 1'b1;
          upd.gpr_idx = rd_dp;
          upd.pc_we   = (rd_dp != ase_pkg::PC_IDX);
          if (opcode == ase_pkg::OPC_MOV) begin
            upd.gpr_data = op2;
          end else if (opcode == ase_pkg::OPC_ADD) begin
            upd.gpr_data = sum;
          end else begin
            upd.gpr_data = diff[31:0];
          end
        end
        ase_pkg::OPC_CMP: begin
          upd.flags_we = 1'b1;
          upd.flags    = cmp_flags;
          upd.pc_we    = 1'b1;
        end
        default: begin
          illegal = 1'b1;
        end
      endcase
    end else if (is_br) begin
      upd.gpr_we   = instr_word[24];
      upd.gpr_idx  = ase_pkg::LR_IDX;
      upd.gpr_data = pc_plus4;
      upd.pc_we    = 1'b1;
      upd.pc_data  = br_target;
    end else begin
      illegal = 1'b1;
    end
  end

  always_comb begin
    if (upd.pc_we) begin
      next_pc = upd.pc_data;
    end else if (upd.gpr_we && (upd.gpr_idx == ase_pkg::PC_IDX)) begin
      next_pc = upd.gpr_data;
    end else begin
      next_pc = pc_data;
    end
    if (upd.gpr_we && (upd.gpr_idx == ase_pkg::R0_IDX)) begin
      return_value = upd.gpr_data;
    end else begin
      return_value = r0_data;
    end
    flags_after = upd.flags_we ? upd.flags : flags;
  end

endmodule

[src/ase_checker.sv]
// ----------------------------------------------------------------------------
// ARM subset execute unit checker
// Port-level properties on request flow and result consistency, bound to
// the top level.
// ----------------------------------------------------------------------------
module ase_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_next_pc,
  input logic        out_halted,
  input logic [31:0] out_return_value
);

  // Halted must track the returned PC being zero.
  a_halted_pc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_halted == (out_next_pc == 32'd0)))
    else $error("halted does not match next_pc");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_next_pc)
      && $stable(out_return_value))
    else $error("stalled result changed");

  // With no result pending the unit always takes a new request.
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output is empty");

  // An accepted request reaches the output once the consumer is ready.
  a_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("accepted request did not produce a result");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind arm_subset_execute_unit ase_port_checker u_ase_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_next_pc      (out_next_pc),
  .out_halted       (out_halted),
  .out_return_value (out_return_value)
);
